/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the blend weight block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define AST_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define AST_ALWAYS(lbl, clk, rst_n, prop)
`define AST_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* hw/rtl/idbw_pkg.sv */
// Types and constants of the inverse distance blend weight block.
package idbw_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PIDX_W     = 6;
    localparam int CNT_W      = 7;
    localparam int COORD_W    = 24;
    localparam int DIST_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIST_W;
    localparam int RAW_W      = 32;
    localparam int SUM_W      = 38;
    localparam int WEIGHT_W   = 16;
    localparam int DIV_W      = RAW_W + WEIGHT_W - 1;
    localparam int NEAR_LSB   = 41;
    localparam int EPS_LSB    = 4;
    localparam int RAW_SHIFT  = 36;
    localparam int CMEM_W     = 3 * COORD_W;
    localparam int DMEM_W     = RAW_W + DIST_W;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_MOVE   = 2'd2,
        OP_EVAL   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_EMIT1,
        S_E_RD,
        S_E_ABS,
        S_E_MUL,
        S_E_ACC,
        S_E_SQRT,
        S_E_SQRTW,
        S_E_STORE,
        S_W_RD,
        S_W_DIV,
        S_W_WAIT,
        S_N_RD,
        S_N_CALC,
        S_N_WAIT,
        S_N_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef struct packed {
        status_t               status;
        logic [PIDX_W-1:0]     point_index;
        logic [WEIGHT_W-1:0]   weight;
        logic [PIDX_W-1:0]     nearest_index;
        logic                  last;
    } out_item_t;

endpackage

/* hw/rtl/idbw_sqrt.sv */
// Iterative integer square root, one result bit per cycle.
module idbw_sqrt import idbw_pkg::*; (
    input  logic              clk,
    input  logic              rstn,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output unit_stat_t        stat,
    output logic [DIST_W-1:0] root
);

    localparam int STEPS = SQ_W / 2;
    localparam int CW    = $clog2(STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [SQ_W-1:0]   rad_reg, rad_next;
    logic [DIST_W+1:0] rem_reg, rem_next;
    logic [DIST_W-1:0] root_reg, root_next;
    logic [DIST_W+1:0] rem_sh, trial;
    logic              ge;

    always_comb begin
        rem_sh    = {rem_reg[DIST_W-1:0], rad_reg[SQ_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        ge        = rem_sh >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[SQ_W-3:0], 2'b00};
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[DIST_W-2:0], ge};
            cnt_next  = cnt_reg + CW'(1);
            if (cnt_reg == CW'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

/* hw/rtl/idbw_div.sv */
// Restoring divider, one quotient bit per cycle.
module idbw_div import idbw_pkg::*; (
    input  logic             clk,
    input  logic             rstn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [SUM_W-1:0] divisor,
    output unit_stat_t       stat,
    output logic [DIV_W-1:0] quotient
);

    localparam int CW = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [SUM_W:0]   rem_reg, rem_next;
    logic [SUM_W-1:0] dvs_reg, dvs_next;
    logic [SUM_W:0]   rem_sh;
    logic             ge;

    always_comb begin
        rem_sh    = {rem_reg[SUM_W-1:0], quo_reg[DIV_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

/* hw/rtl/inverse_distance_blend_weights.sv */
// Inverse distance blend weights: a table of up to 64 points is kept in a coordinate
// memory, and an evaluate beat returns one Q1.15 weight per point plus the nearest
// point. A remove copies each entry above the removed one down by one place. An
// evaluate runs a distance pass (the 25-step square root serves 2D and 3D), then a
// pass for the raw weights and one for the normalized weights, both on the 47-step
// shared divider; with a near point or a single point the raw weight pass is skipped
// and the normalized weights need no division.
// One item is in work at a time; a finished result beat waits in the output register.
`include "assert_macros.svh"
module inverse_distance_blend_weights import idbw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_wdata,   // dimensions
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // index, coord_x, coord_y, coord_z, zero pad
    input  logic [1:0]           s_tuser,     // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,     // point_index, weight, nearest_index, zero pad
    output logic [1:0]           m_tuser,     // status
    output logic                 m_tlast
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [1:0]          dims_reg, dims_next;
    op_t                 op_reg, op_next;
    logic [PIDX_W-1:0]   idx_reg, idx_next;
    logic [COORD_W-1:0]  cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    status_t             res_status_reg, res_status_next;
    logic [PIDX_W-1:0]   res_pi_reg, res_pi_next;
    logic [DIST_W-1:0]   adx_reg, adx_next, ady_reg, ady_next, adz_reg, adz_next;
    logic [SQ_W-1:0]     sq_reg, sq_next, acc_reg, acc_next;
    logic [1:0]          mstep_reg, mstep_next;
    logic [DIST_W-1:0]   min_reg, min_next;
    logic [PIDX_W-1:0]   nearest_reg, nearest_next;
    logic                any_near_reg, any_near_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;

    logic [CMEM_W-1:0]   cmem [MAX_POINTS];
    logic [DMEM_W-1:0]   dmem [MAX_POINTS];
    logic [CMEM_W-1:0]   cmem_q, cmem_wdata;
    logic [DMEM_W-1:0]   dmem_q, dmem_wdata;
    logic [PIDX_W-1:0]   cmem_raddr, cmem_waddr;
    logic                cmem_we, dmem_we;

    logic                sqrt_start, div_start;
    unit_stat_t          sqrt_stat, div_stat;
    logic [DIST_W-1:0]   sqrt_root;
    logic [DIV_W-1:0]    div_dividend, div_quo;
    logic [SUM_W-1:0]    div_divisor;

    logic                out_free, last_pt, mul_last, near_now, any_near_now;
    logic [DIST_W-1:0]   dist_now, dq_dist, mop;
    logic [RAW_W-1:0]    dq_raw;
    logic [CNT_W-1:0]    i_inc;
    logic signed [DIST_W-1:0] dx, dy, dz;

    // Coordinate and distance memories with registered read data.
    always_ff @(posedge aclk) begin
        if (cmem_we) begin
            cmem[cmem_waddr] <= cmem_wdata;
        end
        cmem_q <= cmem[cmem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (dmem_we) begin
            dmem[i_reg[PIDX_W-1:0]] <= dmem_wdata;
        end
        dmem_q <= dmem[i_reg[PIDX_W-1:0]];
    end

    idbw_sqrt u_sqrt (
        .clk      (aclk),
        .rstn     (aresetn),
        .start    (sqrt_start),
        .radicand (acc_reg),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

    idbw_div u_div (
        .clk      (aclk),
        .rstn     (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign out_free     = !out_valid_reg || m_tready;
    assign i_inc        = i_reg + CNT_W'(1);
    assign last_pt      = (i_inc == count_reg);
    assign dq_dist      = dmem_q[DIST_W-1:0];
    assign dq_raw       = dmem_q[DMEM_W-1:DIST_W];
    assign dist_now     = (dims_reg == 2'd1) ? adx_reg : sqrt_root;
    assign near_now     = dist_now < DIST_W'(NEAR_LSB);
    assign any_near_now = any_near_reg || near_now;
    assign mul_last     = (mstep_reg == 2'd2) || (dims_reg == 2'd2 && mstep_reg == 2'd1);
    assign cmem_raddr   = (state_reg == S_SHIFT_CHK) ? i_inc[PIDX_W-1:0]
                                                     : i_reg[PIDX_W-1:0];

    always_comb begin
        dx = $signed({cx_reg[COORD_W-1], cx_reg})
           - $signed({cmem_q[COORD_W-1], cmem_q[COORD_W-1:0]});
        dy = $signed({cy_reg[COORD_W-1], cy_reg})
           - $signed({cmem_q[2*COORD_W-1], cmem_q[2*COORD_W-1:COORD_W]});
        dz = $signed({cz_reg[COORD_W-1], cz_reg})
           - $signed({cmem_q[CMEM_W-1], cmem_q[CMEM_W-1:2*COORD_W]});
        case (mstep_reg)
            2'd0:    mop = adx_reg;
            2'd1:    mop = ady_reg;
            default: mop = adz_reg;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DECODE;
            end
            S_DECODE: begin
                if (op_reg == OP_REMOVE && CNT_W'(idx_reg) < count_reg) begin
                    state_next = S_SHIFT_CHK;
                end else if (op_reg == OP_EVAL && count_reg != '0) begin
                    state_next = S_E_RD;
                end else begin
                    state_next = S_EMIT1;
                end
            end
            S_SHIFT_CHK: state_next = (i_inc < count_reg) ? S_SHIFT_WR : S_EMIT1;
            S_SHIFT_WR:  state_next = S_SHIFT_CHK;
            S_EMIT1: begin
                if (out_free) state_next = S_IDLE;
            end
            S_E_RD:  state_next = S_E_ABS;
            S_E_ABS: state_next = (dims_reg == 2'd1) ? S_E_STORE : S_E_MUL;
            S_E_MUL: state_next = S_E_ACC;
            S_E_ACC: state_next = mul_last ? S_E_SQRT : S_E_MUL;
            S_E_SQRT: state_next = S_E_SQRTW;
            S_E_SQRTW: begin
                if (sqrt_stat.done) state_next = S_E_STORE;
            end
            S_E_STORE: begin
                if (!last_pt) begin
                    state_next = S_E_RD;
                end else if (count_reg != CNT_W'(1) && !any_near_now) begin
                    state_next = S_W_RD;
                end else begin
                    state_next = S_N_RD;
                end
            end
            S_W_RD:  state_next = S_W_DIV;
            S_W_DIV: state_next = S_W_WAIT;
            S_W_WAIT: begin
                if (div_stat.done) state_next = last_pt ? S_N_RD : S_W_RD;
            end
            S_N_RD: state_next = S_N_CALC;
            S_N_CALC: begin
                if (count_reg == CNT_W'(1) || any_near_reg) begin
                    state_next = S_N_EMIT;
                end else begin
                    state_next = S_N_WAIT;
                end
            end
            S_N_WAIT: begin
                if (div_stat.done) state_next = S_N_EMIT;
            end
            S_N_EMIT: begin
                if (out_free) state_next = last_pt ? S_IDLE : S_N_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        count_next      = count_reg;
        dims_next       = cfg_we ? cfg_wdata : dims_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        i_next          = i_reg;
        res_status_next = res_status_reg;
        res_pi_next     = res_pi_reg;
        adx_next        = adx_reg;
        ady_next        = ady_reg;
        adz_next        = adz_reg;
        sq_next         = sq_reg;
        acc_next        = acc_reg;
        mstep_next      = mstep_reg;
        min_next        = min_reg;
        nearest_next    = nearest_reg;
        any_near_next   = any_near_reg;
        sum_next        = sum_reg;
        w_next          = w_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        cmem_we         = 1'b0;
        cmem_waddr      = i_reg[PIDX_W-1:0];
        cmem_wdata      = {cz_reg, cy_reg, cx_reg};
        dmem_we         = 1'b0;
        dmem_wdata      = {dq_raw, dq_dist};
        sqrt_start      = 1'b0;
        div_start       = 1'b0;
        div_dividend    = {dq_raw, {(WEIGHT_W-1){1'b0}}};
        div_divisor     = sum_reg;
        s_tready        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                op_next  = op_t'(s_tuser);
                idx_next = s_tdata[PIDX_W-1:0];
                cx_next  = s_tdata[PIDX_W +: COORD_W];
                cy_next  = s_tdata[PIDX_W+COORD_W +: COORD_W];
                cz_next  = s_tdata[PIDX_W+2*COORD_W +: COORD_W];
            end
            S_DECODE: begin
                res_status_next = STAT_OK;
                res_pi_next     = idx_reg;
                i_next          = '0;
                any_near_next   = 1'b0;
                case (op_reg)
                    OP_ADD: begin
                        if (count_reg >= CNT_W'(MAX_POINTS)) begin
                            res_status_next = STAT_FULL;
                            res_pi_next     = '0;
                        end else begin
                            cmem_we     = 1'b1;
                            cmem_waddr  = count_reg[PIDX_W-1:0];
                            res_pi_next = count_reg[PIDX_W-1:0];
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    OP_REMOVE, OP_MOVE: begin
                        if (CNT_W'(idx_reg) >= count_reg) begin
                            res_status_next = STAT_RANGE;
                        end else if (op_reg == OP_MOVE) begin
                            cmem_we    = 1'b1;
                            cmem_waddr = idx_reg;
                        end else begin
                            i_next = CNT_W'(idx_reg);
                        end
                    end
                    default: begin
                        if (count_reg == '0) begin
                            res_status_next = STAT_EMPTY;
                            res_pi_next     = '0;
                        end
                    end
                endcase
            end
            S_SHIFT_CHK: begin
                if (i_inc >= count_reg) count_next = count_reg - CNT_W'(1);
            end
            S_SHIFT_WR: begin
                // The entry above was read in the previous cycle; copy it down.
                cmem_we    = 1'b1;
                cmem_wdata = cmem_q;
                i_next     = i_inc;
            end
            S_EMIT1: begin
                if (out_free) begin
                    out_valid_next        = 1'b1;
                    out_next.status       = res_status_reg;
                    out_next.point_index  = res_pi_reg;
                    out_next.weight       = '0;
                    out_next.nearest_index = '0;
                    out_next.last         = 1'b1;
                end
            end
            S_E_ABS: begin
                adx_next   = dx[DIST_W-1] ? DIST_W'(-dx) : DIST_W'(dx);
                ady_next   = dy[DIST_W-1] ? DIST_W'(-dy) : DIST_W'(dy);
                adz_next   = dz[DIST_W-1] ? DIST_W'(-dz) : DIST_W'(dz);
                acc_next   = '0;
                mstep_next = '0;
            end
            S_E_MUL: sq_next = mop * mop;
            S_E_ACC: begin
                acc_next   = acc_reg + sq_reg;
                mstep_next = mstep_reg + 2'd1;
            end
            S_E_SQRT: sqrt_start = 1'b1;
            S_E_STORE: begin
                dmem_we       = 1'b1;
                dmem_wdata    = {{RAW_W{1'b0}}, dist_now};
                any_near_next = any_near_now;
                // The first point at the smallest distance wins.
                if (i_reg == '0 || dist_now < min_reg) begin
                    min_next     = dist_now;
                    nearest_next = i_reg[PIDX_W-1:0];
                end
                sum_next = '0;
                i_next   = last_pt ? '0 : i_inc;
            end
            S_W_DIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(1) << RAW_SHIFT;
                div_divisor  = SUM_W'(dq_dist) + SUM_W'(EPS_LSB);
            end
            S_W_WAIT: begin
                if (div_stat.done) begin
                    dmem_we    = 1'b1;
                    dmem_wdata = {div_quo[RAW_W-1:0], dq_dist};
                    sum_next   = sum_reg + SUM_W'(div_quo[RAW_W-1:0]);
                    i_next     = last_pt ? '0 : i_inc;
                end
            end
            S_N_CALC: begin
                if (count_reg == CNT_W'(1)) begin
                    w_next = WEIGHT_W'(1) << (WEIGHT_W - 1);
                end else if (any_near_reg) begin
                    w_next = (dq_dist < DIST_W'(NEAR_LSB))
                           ? (WEIGHT_W'(1) << (WEIGHT_W - 1)) : '0;
                end else begin
                    div_start = 1'b1;
                end
            end
            S_N_WAIT: begin
                if (div_stat.done) w_next = div_quo[WEIGHT_W-1:0];
            end
            S_N_EMIT: begin
                if (out_free) begin
                    out_valid_next         = 1'b1;
                    out_next.status        = STAT_OK;
                    out_next.point_index   = i_reg[PIDX_W-1:0];
                    out_next.weight        = w_reg;
                    out_next.nearest_index = nearest_reg;
                    out_next.last          = last_pt;
                    i_next                 = i_inc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dims_reg      <= 2'd1;
            out_valid_reg <= 1'b0;
            any_near_reg  <= 1'b0;
            sum_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dims_reg      <= dims_next;
            out_valid_reg <= out_valid_next;
            any_near_reg  <= any_near_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        cz_reg         <= cz_next;
        i_reg          <= i_next;
        res_status_reg <= res_status_next;
        res_pi_reg     <= res_pi_next;
        adx_reg        <= adx_next;
        ady_reg        <= ady_next;
        adz_reg        <= adz_next;
        sq_reg         <= sq_next;
        acc_reg        <= acc_next;
        mstep_reg      <= mstep_next;
        min_reg        <= min_next;
        nearest_reg    <= nearest_next;
        w_reg          <= w_next;
        out_reg        <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {{(M_TDATA_W - 2*PIDX_W - WEIGHT_W){1'b0}},
                       out_reg.nearest_index, out_reg.weight, out_reg.point_index};

    `AST_NEVER(a_count_bound, aclk, aresetn, count_reg > CNT_W'(MAX_POINTS))
    `AST_ALWAYS(a_units_idle_on_accept, aclk, aresetn, (s_tvalid && s_tready) |-> (!div_stat.busy && !sqrt_stat.busy))
    `AST_ALWAYS(a_nearest_in_table, aclk, aresetn, (state_reg == S_N_EMIT) |-> (CNT_W'(nearest_reg) < count_reg))

endmodule

/* test/testbench.sv */
// Self-checking testbench for the inverse distance blend weight block.
module testbench;
    import idbw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_t             status;
        logic [PIDX_W-1:0]   point_index;
        logic [WEIGHT_W-1:0] weight;
        logic [PIDX_W-1:0]   nearest_index;
        logic                last;
    } blend_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_wdata = 2'd1;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = OP_ADD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    inverse_distance_blend_weights i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Shadow copy of the point table and the dimension register.
    logic signed [COORD_W-1:0] pt_x[MAX_POINTS];
    logic signed [COORD_W-1:0] pt_y[MAX_POINTS];
    logic signed [COORD_W-1:0] pt_z[MAX_POINTS];
    int            pt_count = 0;
    logic [1:0]    dims = 2'd1;

    blend_result_t expected_results[$];
    int            error_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #500ms;
        $display("testbench failed");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned abs_delta(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
        longint signed d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? -d : d;
    endfunction

    task automatic push_result(status_t st, int pi, longint unsigned w, int ni, bit lst);
        blend_result_t r;
        r.status = st;
        r.point_index = pi[PIDX_W-1:0];
        r.weight = w[WEIGHT_W-1:0];
        r.nearest_index = ni[PIDX_W-1:0];
        r.last = lst;
        expected_results.push_back(r);
    endtask

    // Applies one accepted beat to the shadow table and queues its results.
    task automatic predict_blend(op_t op, logic [5:0] idx, logic signed [COORD_W-1:0] x,
                                 logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
        longint unsigned pt_dist[MAX_POINTS];
        longint unsigned raw[MAX_POINTS];
        longint unsigned sum, s, w;
        int nearest;
        bit any_near;
        case (op)
            OP_ADD: begin
                if (pt_count >= MAX_POINTS) begin
                    push_result(STAT_FULL, 0, 0, 0, 1'b1);
                end else begin
                    pt_x[pt_count] = x;
                    pt_y[pt_count] = y;
                    pt_z[pt_count] = z;
                    push_result(STAT_OK, pt_count, 0, 0, 1'b1);
                    pt_count++;
                end
            end
            OP_REMOVE, OP_MOVE: begin
                if (idx >= pt_count) begin
                    push_result(STAT_RANGE, idx, 0, 0, 1'b1);
                end else begin
                    if (op == OP_REMOVE) begin
                        for (int i = idx; i + 1 < pt_count; i++) begin
                            pt_x[i] = pt_x[i+1];
                            pt_y[i] = pt_y[i+1];
                            pt_z[i] = pt_z[i+1];
                        end
                        pt_count--;
                    end else begin
                        pt_x[idx] = x;
                        pt_y[idx] = y;
                        pt_z[idx] = z;
                    end
                    push_result(STAT_OK, idx, 0, 0, 1'b1);
                end
            end
            default: begin
                if (pt_count == 0) begin
                    push_result(STAT_EMPTY, 0, 0, 0, 1'b1);
                end else begin
                    nearest = 0;
                    any_near = 1'b0;
                    for (int i = 0; i < pt_count; i++) begin
                        if (dims == 2'd1) begin
                            pt_dist[i] = abs_delta(x, pt_x[i]);
                        end else begin
                            s = abs_delta(x, pt_x[i]) ** 2 + abs_delta(y, pt_y[i]) ** 2;
                            if (dims != 2'd2) s = s + abs_delta(z, pt_z[i]) ** 2;
                            pt_dist[i] = int_sqrt(s);
                        end
                        if (pt_dist[i] < pt_dist[nearest]) nearest = i;
                        if (pt_dist[i] < NEAR_LSB) any_near = 1'b1;
                    end
                    sum = 0;
                    if (pt_count > 1 && !any_near) begin
                        for (int i = 0; i < pt_count; i++) begin
                            raw[i] = (64'd1 << RAW_SHIFT) / (pt_dist[i] + EPS_LSB);
                            sum += raw[i];
                        end
                    end
                    for (int i = 0; i < pt_count; i++) begin
                        if (pt_count == 1) w = 64'd1 << (WEIGHT_W - 1);
                        else if (any_near)
                            w = (pt_dist[i] < NEAR_LSB) ? 64'd1 << (WEIGHT_W - 1) : 0;
                        else w = (raw[i] << (WEIGHT_W - 1)) / sum;
                        push_result(STAT_OK, i, w, nearest, i + 1 == pt_count);
                    end
                end
            end
        endcase
    endtask

    // Sends one beat; tvalid stays high afterwards so back-to-back beats need no gap.
    task automatic send_item(op_t op, logic [5:0] idx, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, z, y, x, idx};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        predict_blend(op, idx, x, y, z);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_dims(logic [1:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        dims = v;
    endtask

    // Query or point position: sometimes near a stored point, sometimes anywhere, mostly in a window around the origin.
    task automatic pick_coords(output logic signed [COORD_W-1:0] x,
                               output logic signed [COORD_W-1:0] y,
                               output logic signed [COORD_W-1:0] z);
        int mode, j;
        mode = $urandom_range(9);
        if (mode < 2) begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
            z = COORD_W'($urandom);
        end else if (mode < 4 && pt_count > 0) begin
            j = $urandom_range(pt_count - 1);
            x = COORD_W'(int'(pt_x[j]) + int'($urandom_range(20)) - 10);
            y = COORD_W'(int'(pt_y[j]) + int'($urandom_range(20)) - 10);
            z = COORD_W'(int'(pt_z[j]) + int'($urandom_range(20)) - 10);
        end else begin
            x = COORD_W'(int'($urandom_range(131072)) - 65536);
            y = COORD_W'(int'($urandom_range(131072)) - 65536);
            z = COORD_W'(int'($urandom_range(131072)) - 65536);
        end
    endtask

    task automatic clear_table();
        while (pt_count > 0) send_item(OP_REMOVE, 6'd0, 0, 0, 0);
    endtask

    task automatic test_directed();
        set_dims(2'd1);
        send_item(OP_EVAL, 6'd0, 0, 0, 0);
        send_item(OP_ADD, 6'd63, 24'sh800000, 24'sh800000, 24'sh800000);
        send_item(OP_EVAL, 6'd0, 24'sh7FFFFF, 0, 0);
        send_item(OP_ADD, 6'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_item(OP_ADD, 6'd5, 24'sd4096, -24'sd4096, 24'sd0);
        send_item(OP_EVAL, 6'd0, 24'sd0, 24'sd0, 24'sd0);
        send_item(OP_EVAL, 6'd0, 24'sd4096, 24'sd9, -24'sd9);
        send_item(OP_ADD, 6'd0, 24'sd4100, 24'sd0, 24'sd0);
        send_item(OP_EVAL, 6'd0, 24'sd4098, 24'sd0, 24'sd0);
        send_item(OP_REMOVE, 6'd63, 0, 0, 0);
        send_item(OP_MOVE, 6'd4, 0, 0, 0);
        send_item(OP_MOVE, 6'd1, -24'sd1, 24'sd1, 24'sd2);
        send_item(OP_EVAL, 6'd0, 24'sd40, 24'sd0, 24'sd0);
        send_item(OP_REMOVE, 6'd3, 0, 0, 0);
        send_item(OP_REMOVE, 6'd0, 0, 0, 0);
        send_item(OP_EVAL, 6'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        set_dims(2'd3);
        send_item(OP_EVAL, 6'd0, 24'sh800000, 24'sh800000, 24'sh800000);
        set_dims(2'd2);
        send_item(OP_EVAL, 6'd0, 24'sh800000, 24'sh800000, 24'sd0);
        set_dims(2'd0);
        send_item(OP_EVAL, 6'd0, 24'sd12, 24'sd3000, -24'sd3000);
    endtask

    task automatic test_full_table();
        logic signed [COORD_W-1:0] x, y, z;
        set_dims(2'd3);
        clear_table();
        while (pt_count < MAX_POINTS) begin
            pick_coords(x, y, z);
            send_item(OP_ADD, 6'($urandom), x, y, z);
        end
        send_item(OP_ADD, 6'd0, 0, 0, 0);
        pick_coords(x, y, z);
        send_item(OP_EVAL, 6'd0, x, y, z);
        send_item(OP_MOVE, 6'd63, x, y, z);
        send_item(OP_REMOVE, 6'd63, 0, 0, 0);
        send_item(OP_MOVE, 6'd63, 0, 0, 0);
        send_item(OP_REMOVE, 6'd0, 0, 0, 0);
        while (pt_count > 8) send_item(OP_REMOVE, 6'($urandom_range(pt_count - 1)), 0, 0, 0);
    endtask

    task automatic test_backpressure();
        logic signed [COORD_W-1:0] x, y, z;
        wait_idle();
        send_idle_pct = 0;
        hold_cycles = 2000;
        repeat (12) begin
            pick_coords(x, y, z);
            send_item(($urandom_range(1) != 0) ? OP_EVAL : OP_ADD, 6'd0, x, y, z);
        end
    endtask

    task automatic test_random(int count);
        logic signed [COORD_W-1:0] x, y, z;
        logic [5:0] idx;
        int r;
        op_t op;
        for (int n = 0; n < count; n++) begin
            if (n % (count / 8) == 0) begin
                set_dims(2'(n / (count / 8) % 4));
                case (n / (count / 4))
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                    default: begin send_idle_pct = 14; recv_stall_pct = 14; end
                endcase
            end
            r = $urandom_range(99);
            if (pt_count < 3) r = r % 40;
            else if (pt_count > 20) r = 30 + r % 70;
            if (r < 30) op = OP_ADD;
            else if (r < 50) op = OP_REMOVE;
            else if (r < 65) op = OP_MOVE;
            else op = OP_EVAL;
            idx = ($urandom_range(9) == 0 || pt_count == 0) ? 6'($urandom_range(63))
                                                             : 6'($urandom_range(pt_count - 1));
            pick_coords(x, y, z);
            send_item(op, idx, x, y, z);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        blend_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no expectation: tdata %h", m_tdata);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tuser != exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[5:0] != exp_r.point_index) begin
                    $error("point_index: expected %0d, got %0d", exp_r.point_index,
                           m_tdata[5:0]);
                    error_count++;
                end
                if (m_tdata[21:6] != exp_r.weight) begin
                    $error("weight: expected %0d, got %0d", exp_r.weight, m_tdata[21:6]);
                    error_count++;
                end
                if (m_tdata[27:22] != exp_r.nearest_index) begin
                    $error("nearest_index: expected %0d, got %0d", exp_r.nearest_index,
                           m_tdata[27:22]);
                    error_count++;
                end
                if (m_tlast != exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_full_table();
        test_backpressure();
        test_random(64);
        wait_idle();
        repeat (200) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/idbw_pkg.sv
hw/rtl/idbw_sqrt.sv
hw/rtl/idbw_div.sv
hw/rtl/inverse_distance_blend_weights.sv
test/testbench.sv
